@@ sv/text_line_formatter_caret_top_defines.svh @@
// Assertion macros used by the port-level checker of the text line formatter.
`ifndef TEXT_LINE_FORMATTER_CARET_TOP_DEFINES_SVH
`define TEXT_LINE_FORMATTER_CARET_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLFC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("tlfc: same-cycle port property violated");

// Next-cycle implication, disabled while reset is asserted.
`define TLFC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("tlfc: next-cycle port property violated");

`endif

@@ sv/tlfc_pkg.sv @@
// Shared types, constants and rendering functions of the text line formatter.
package tlfc_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int DIGIT_W       = 4;
    localparam int NUM_W         = NUMBER_DIGITS * DIGIT_W;

    localparam int BODY_MAX   = 4;
    localparam int BODY_IDX_W = $clog2(BODY_MAX);
    localparam int BODY_CNT_W = $clog2(BODY_MAX + 1);

    localparam int SEQ_IDX_W  = $clog2(NUMBER_DIGITS + BODY_MAX + 2);

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOW_NONPRINTING = 3'd0,
        CFG_SHOW_ENDS        = 3'd1,
        CFG_SHOW_TABS        = 3'd2,
        CFG_NUMBER_ALL       = 3'd3,
        CFG_NUMBER_NONBLANK  = 3'd4,
        CFG_SQUEEZE_BLANK    = 3'd5
    } cfg_idx_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [1:0] BLANK_RUN_MAX = 2'd2;

    typedef struct packed {
        logic show_nonprinting;
        logic show_ends;
        logic show_tabs;
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
    } cfg_t;

    // One queued line-level job: optional number prefix, then one rendered body.
    typedef struct packed {
        logic             has_num;
        logic [NUM_W-1:0] num;
        logic             line_end;
        logic [7:0]       data;
    } job_t;

    typedef struct packed {
        logic [BODY_MAX-1:0][7:0] bytes;
        logic [BODY_CNT_W-1:0]    cnt;
    } body_t;

    // Decimal counter increment in BCD, holding at all nines.
    function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] v);
        logic [NUM_W-1:0]   r;
        logic               carry;
        logic               all_nine;
        logic [DIGIT_W-1:0] d;
        r        = v;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[i*DIGIT_W +: DIGIT_W] != DIGIT_W'(9)) begin
                all_nine = 1'b0;
            end
        end
        if (!all_nine) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                d = r[i*DIGIT_W +: DIGIT_W];
                if (carry) begin
                    if (d == DIGIT_W'(9)) begin
                        r[i*DIGIT_W +: DIGIT_W] = '0;
                    end else begin
                        r[i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(1);
                        carry = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    // Expands one body byte (or a line end) into its display sequence.
    function automatic body_t render(input logic line_end, input logic [7:0] b,
                                     input cfg_t cfg);
        body_t                 r;
        logic [7:0]            lo;
        logic [7:0]            t0;
        logic [7:0]            t1;
        logic [BODY_CNT_W-1:0] tn;
        r  = '0;
        lo = {1'b0, b[6:0]};
        t0 = lo;
        t1 = '0;
        tn = BODY_CNT_W'(1);
        if (lo < 8'd32) begin
            t0 = CH_CARET;
            t1 = lo + 8'd64;
            tn = BODY_CNT_W'(2);
        end else if (lo == CH_DEL) begin
            t0 = CH_CARET;
            t1 = CH_QMARK;
            tn = BODY_CNT_W'(2);
        end
        priority if (line_end) begin
            if (cfg.show_ends) begin
                r.bytes[0] = CH_DOLLAR;
                r.bytes[1] = CH_LF;
                r.cnt      = BODY_CNT_W'(2);
            end else begin
                r.bytes[0] = CH_LF;
                r.cnt      = BODY_CNT_W'(1);
            end
        end else if (cfg.show_tabs && b == CH_TAB) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = CH_UPPER_I;
            r.cnt      = BODY_CNT_W'(2);
        end else if (!cfg.show_nonprinting || b == CH_TAB) begin
            r.bytes[0] = b;
            r.cnt      = BODY_CNT_W'(1);
        end else if (b[7]) begin
            r.bytes[0] = CH_UPPER_M;
            r.bytes[1] = CH_DASH;
            r.bytes[2] = t0;
            r.bytes[3] = t1;
            r.cnt      = BODY_CNT_W'(2) + tn;
        end else begin
            r.bytes[0] = t0;
            r.bytes[1] = t1;
            r.cnt      = tn;
        end
        return r;
    endfunction

endpackage

@@ sv/tlfc_front.sv @@
// Front end: configuration registers, line state, counters and job classification.
module tlfc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data,
    input  logic                             accept,
    input  logic                             req_type,
    input  logic [7:0]                       data_byte,
    output logic                             job_valid,
    output tlfc_pkg::job_t                   job,
    output tlfc_pkg::cfg_t                   cfg
);

    tlfc_pkg::cfg_t                  cfg_reg;
    logic                            at_ls_reg, at_ls_next;
    logic [tlfc_pkg::NUM_W-1:0]      cnt_all_reg, cnt_all_next;
    logic [tlfc_pkg::NUM_W-1:0]      cnt_nb_reg, cnt_nb_next;
    logic [1:0]                      blank_run_reg, blank_run_next;
    logic                            blank;

    assign cfg = cfg_reg;

    always_comb begin
        job            = '0;
        job_valid      = 1'b0;
        at_ls_next     = at_ls_reg;
        cnt_all_next   = cnt_all_reg;
        cnt_nb_next    = cnt_nb_reg;
        blank_run_next = blank_run_reg;
        blank          = (data_byte == tlfc_pkg::CH_LF);
        if (accept) begin
            priority if (req_type) begin
                // End of file closes an open line and restarts numbering.
                job.line_end = 1'b1;
                job_valid    = !at_ls_reg;
                at_ls_next   = 1'b1;
                cnt_all_next = tlfc_pkg::NUM_W'(1);
                cnt_nb_next  = tlfc_pkg::NUM_W'(1);
            end else if (at_ls_reg) begin
                if (cfg_reg.squeeze_blank) begin
                    if (!blank) begin
                        blank_run_next = '0;
                    end else if (blank_run_reg < tlfc_pkg::BLANK_RUN_MAX) begin
                        blank_run_next = blank_run_reg + 2'd1;
                    end
                end
                if (!(cfg_reg.squeeze_blank && blank_run_next == tlfc_pkg::BLANK_RUN_MAX)) begin
                    job_valid    = 1'b1;
                    job.line_end = blank;
                    job.data     = data_byte;
                    if (cfg_reg.number_nonblank) begin
                        if (!blank) begin
                            job.has_num = 1'b1;
                            job.num     = cnt_nb_reg;
                            cnt_nb_next = tlfc_pkg::bcd_inc(cnt_nb_reg);
                        end
                    end else if (cfg_reg.number_all) begin
                        job.has_num  = 1'b1;
                        job.num      = cnt_all_reg;
                        cnt_all_next = tlfc_pkg::bcd_inc(cnt_all_reg);
                    end
                    if (!blank) begin
                        at_ls_next = 1'b0;
                    end
                end
            end else begin
                job_valid    = 1'b1;
                job.line_end = blank;
                job.data     = data_byte;
                at_ls_next   = blank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg       <= '0;
            at_ls_reg     <= 1'b1;
            cnt_all_reg   <= tlfc_pkg::NUM_W'(1);
            cnt_nb_reg    <= tlfc_pkg::NUM_W'(1);
            blank_run_reg <= '0;
        end else begin
            at_ls_reg     <= at_ls_next;
            cnt_all_reg   <= cnt_all_next;
            cnt_nb_reg    <= cnt_nb_next;
            blank_run_reg <= blank_run_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    tlfc_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                    tlfc_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                    tlfc_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                    tlfc_pkg::CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                    tlfc_pkg::CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                    tlfc_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sv/tlfc_queue.sv @@
// Small job queue between the front end and the byte emitter.
module tlfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tlfc_pkg::job_t push_job,
    input  logic           pop,
    output tlfc_pkg::job_t head,
    output logic           empty,
    output logic           full
);

    tlfc_pkg::job_t                    slots [tlfc_pkg::QDEPTH];
    logic [tlfc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tlfc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tlfc_pkg::QCOUNT_W-1:0]     count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == tlfc_pkg::QCOUNT_W'(tlfc_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + tlfc_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + tlfc_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + tlfc_pkg::QCOUNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - tlfc_pkg::QCOUNT_W'(1);
            end
        end
    end

endmodule

@@ sv/tlfc_back.sv @@
// Back end: walks one job byte by byte into the output register.
module tlfc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tlfc_pkg::cfg_t cfg,
    input  tlfc_pkg::job_t head,
    input  logic           head_empty,
    output logic           head_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           last
);

    logic [tlfc_pkg::SEQ_IDX_W-1:0]  idx_reg;
    logic [7:0]                      out_byte_reg;
    logic                            out_last_reg;
    logic                            out_valid_reg;

    tlfc_pkg::body_t                 body;
    logic [tlfc_pkg::SEQ_IDX_W-1:0]  pre;
    logic [tlfc_pkg::SEQ_IDX_W-1:0]  total;
    logic [tlfc_pkg::SEQ_IDX_W-1:0]  body_pos;
    logic [tlfc_pkg::DIGIT_W-1:0]    digit;
    logic                            seen;
    logic                            adv;
    logic                            emit;
    logic                            is_last;
    logic [7:0]                      cur_byte;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last     = out_last_reg;

    always_comb begin
        body     = tlfc_pkg::render(head.line_end, head.data, cfg);
        pre      = head.has_num ? tlfc_pkg::SEQ_IDX_W'(tlfc_pkg::NUMBER_DIGITS + 1) : '0;
        total    = pre + tlfc_pkg::SEQ_IDX_W'(body.cnt);
        body_pos = idx_reg - pre;
        is_last  = (idx_reg == total - tlfc_pkg::SEQ_IDX_W'(1));
        adv      = !out_valid_reg || pop;
        emit     = !head_empty && adv;
        head_pop = emit && is_last;
        seen     = 1'b0;
        digit    = '0;
        cur_byte = body.bytes[body_pos[tlfc_pkg::BODY_IDX_W-1:0]];
        if (head.has_num && idx_reg == tlfc_pkg::SEQ_IDX_W'(tlfc_pkg::NUMBER_DIGITS)) begin
            cur_byte = tlfc_pkg::CH_TAB;
        end
        // Digit 0 is the most significant; leading zeros become spaces.
        for (int i = 0; i < tlfc_pkg::NUMBER_DIGITS; i++) begin
            digit = head.num[tlfc_pkg::NUM_W - 1 - i*tlfc_pkg::DIGIT_W -: tlfc_pkg::DIGIT_W];
            seen  = seen || (digit != '0);
            if (head.has_num && idx_reg == tlfc_pkg::SEQ_IDX_W'(i)) begin
                if (seen || i == tlfc_pkg::NUMBER_DIGITS - 1) begin
                    cur_byte = tlfc_pkg::CH_ZERO + 8'(digit);
                end else begin
                    cur_byte = tlfc_pkg::CH_SPACE;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (emit) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + tlfc_pkg::SEQ_IDX_W'(1);
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/text_line_formatter_caret_top.sv @@
// Top level of the streaming text line formatter with caret notation.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------
//   input     push / full          req_type, data_byte
//   result    pop / empty          out_byte, last
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item's words, none up to eleven (six number digits, a tab and four body
// bytes), leave the emitter at one per cycle while the result side keeps popping.
// With the path idle, an accepted word goes into the job queue, then is rendered
// into the output register, from which it shows on the result ports. Reset clears
// the options and sets both line counters and the line-start flag, with no
// clearing pass. A result-side stall backs up into the four-entry job queue.
module text_line_formatter_caret_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input words.
    input  logic                            push,
    output logic                            full,
    input  logic                            req_type,
    input  logic [7:0]                      data_byte,
    // Result words.
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_byte,
    output logic                            last,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tlfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);

    tlfc_pkg::cfg_t cfg;
    tlfc_pkg::job_t job;
    tlfc_pkg::job_t head;
    logic           job_valid;
    logic           head_empty;
    logic           head_pop;
    logic           accept;

    // Always ready; the user must change options only while idle; this is not enforced.
    assign cfg_ready = 1'b1;

    // An input word is taken whenever the job queue has room, even while the
    // output register still holds a word nobody has popped.
    assign accept = push && !full;

    // The front end classifies each word and updates the line state in the
    // cycle it is accepted, producing at most one job.
    tlfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req_type  (req_type),
        .data_byte (data_byte),
        .job_valid (job_valid),
        .job       (job),
        .cfg       (cfg)
    );

    // Jobs wait here so the front end keeps taking words while the emitter
    // is busy with a long prefix.
    tlfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (head_pop),
        .head     (head),
        .empty    (head_empty),
        .full     (full)
    );

    // The emitter renders the head job one word per cycle while the result side
    // keeps popping, and releases it after its final word.
    tlfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule

@@ sv/tlfc_checker.sv @@
// Port-level checker of the text line formatter, bound to the top level.
`include "text_line_formatter_caret_top_defines.svh"

module tlfc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            req_type,
    input logic [7:0]                      data_byte,
    input logic                            empty,
    input logic                            pop,
    input logic [7:0]                      out_byte,
    input logic                            last,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [tlfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic                            cfg_data
);

    // A waiting result word holds until it is popped.
    `TLFC_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(last))

    // Words of one item come out without gaps.
    `TLFC_ASSERT_NEXT(a_burst, clk, rst_n, !empty && pop && !last, !empty)

    // A line end is always the final word of its item.
    `TLFC_ASSERT_IMP(a_lf_last, clk, rst_n, !empty && out_byte == tlfc_pkg::CH_LF, last)

    // The queue fills only through an input word.
    `TLFC_ASSERT_IMP(a_full_rise, clk, rst_n, $rose(full), $past(push))

endmodule

bind text_line_formatter_caret_top tlfc_checker u_checker (.*);

@@ tb/sv/text_line_formatter_caret_top_tb.sv @@
// Self-checking testbench for the streaming text line formatter with caret notation.
localparam logic REQ_DATA = 1'b0;
localparam logic REQ_EOF  = 1'b1;

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} fmt_word_t;

// Tracks the formatter's options and line state and holds the words it must emit.
class formatted_byte_tracker;
    bit          show_nonprinting;
    bit          show_ends;
    bit          show_tabs;
    bit          number_all;
    bit          number_nonblank;
    bit          squeeze_blank;
    bit          line_open;
    int unsigned all_lines;
    int unsigned nonblank_lines;
    logic [1:0]  blank_run;
    int unsigned count_cap;
    int unsigned mismatches;
    fmt_word_t   awaited_bytes[$];
    fmt_word_t   step_words[$];

    function new();
        count_cap = 1;
        repeat (tlfc_pkg::NUMBER_DIGITS) count_cap *= 10;
        count_cap--;
        line_open = 1'b0;
        all_lines = 1;
        nonblank_lines = 1;
        blank_run = '0;
        mismatches = 0;
    endfunction

    function void write_option(tlfc_pkg::cfg_idx_t idx, bit val);
        case (idx)
            tlfc_pkg::CFG_SHOW_NONPRINTING: show_nonprinting = val;
            tlfc_pkg::CFG_SHOW_ENDS:        show_ends = val;
            tlfc_pkg::CFG_SHOW_TABS:        show_tabs = val;
            tlfc_pkg::CFG_NUMBER_ALL:       number_all = val;
            tlfc_pkg::CFG_NUMBER_NONBLANK:  number_nonblank = val;
            tlfc_pkg::CFG_SQUEEZE_BLANK:    squeeze_blank = val;
            default: ;
        endcase
    endfunction

    function void emit(logic [7:0] ch);
        fmt_word_t w;
        w.ch = ch;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    // Right-aligned, space-padded decimal count and a tab; returns the next count.
    function int unsigned emit_line_number(int unsigned count);
        int unsigned place;
        place = count_cap / 10 + 1;
        while (place > 0)
        begin
            if (count >= place || place == 1)
                emit(tlfc_pkg::CH_ZERO + 8'((count / place) % 10));
            else
                emit(tlfc_pkg::CH_SPACE);
            place /= 10;
        end
        emit(tlfc_pkg::CH_TAB);
        return (count < count_cap) ? count + 1 : count;
    endfunction

    function void emit_line_end();
        if (show_ends)
            emit(tlfc_pkg::CH_DOLLAR);
        emit(tlfc_pkg::CH_LF);
    endfunction

    function void emit_rendered(logic [7:0] b);
        logic [7:0] low;
        low = {1'b0, b[6:0]};
        if (show_tabs && b == tlfc_pkg::CH_TAB)
        begin
            emit(tlfc_pkg::CH_CARET);
            emit(tlfc_pkg::CH_UPPER_I);
        end
        else if (!show_nonprinting || b == tlfc_pkg::CH_TAB)
            emit(b);
        else
        begin
            if (b[7])
            begin
                emit(tlfc_pkg::CH_UPPER_M);
                emit(tlfc_pkg::CH_DASH);
            end
            if (low < 8'd32)
            begin
                emit(tlfc_pkg::CH_CARET);
                emit(low + 8'd64);
            end
            else if (low == tlfc_pkg::CH_DEL)
            begin
                emit(tlfc_pkg::CH_CARET);
                emit(tlfc_pkg::CH_QMARK);
            end
            else
                emit(low);
        end
    endfunction

    // Works out the words that one accepted input word causes.
    function void take_input(logic req, logic [7:0] b);
        bit blank;
        step_words.delete();
        if (req == REQ_EOF)
        begin
            if (line_open)
                emit_line_end();
            line_open = 1'b0;
            all_lines = 1;
            nonblank_lines = 1;
        end
        else if (!line_open)
        begin
            blank = (b == tlfc_pkg::CH_LF);
            if (squeeze_blank)
            begin
                if (!blank)
                    blank_run = '0;
                else if (blank_run < tlfc_pkg::BLANK_RUN_MAX)
                    blank_run++;
            end
            // A squeezed line leaves the line counters and the line state alone.
            if (!(squeeze_blank && blank_run >= tlfc_pkg::BLANK_RUN_MAX))
            begin
                if (number_nonblank)
                begin
                    if (!blank)
                        nonblank_lines = emit_line_number(nonblank_lines);
                end
                else if (number_all)
                    all_lines = emit_line_number(all_lines);
                if (blank)
                    emit_line_end();
                else
                begin
                    emit_rendered(b);
                    line_open = 1'b1;
                end
            end
        end
        else if (b == tlfc_pkg::CH_LF)
        begin
            emit_line_end();
            line_open = 1'b0;
        end
        else
            emit_rendered(b);
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            awaited_bytes.push_back(step_words[i]);
    endfunction

    function void check_output(logic [7:0] ch, logic last);
        fmt_word_t want;
        if (awaited_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: out_byte 0x%02h last %0b with nothing pending",
                         ch, last);
        end
        else
        begin
            want = awaited_bytes.pop_front();
            if (ch !== want.ch || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: out_byte 0x%02h last %0b, expected 0x%02h last %0b",
                             ch, last, want.ch, want.last);
            end
        end
    endfunction

    function int unsigned pending();
        return awaited_bytes.size();
    endfunction
endclass

module text_line_formatter_caret_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass once nothing is pending, so that input words with no
    // output (squeezed lines, end-of-file marks at a line start) have been taken in.
    localparam int DRAIN_CYCLES = 32;
    // Cycles with no word moving on any channel before the run is abandoned.
    localparam int STALL_LIMIT  = 1000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           req_type = REQ_DATA;
    logic [7:0]                     data_byte = 8'h00;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [7:0]                     out_byte;
    logic                           last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tlfc_pkg::CFG_IDX_W-1:0] cfg_index = tlfc_pkg::CFG_SHOW_NONPRINTING;
    logic                           cfg_data = 1'b0;

    // When set, the sender or the receiver runs back to back with no idle cycles.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    formatted_byte_tracker fmt_tracker;

    text_line_formatter_caret_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Writes all six option registers; bit i of opts goes to register i.
    // Called only while the block is idle. valid stays high across the writes
    // and is lowered once after the last one.
    task automatic apply_options(input bit [5:0] opts);
        tlfc_pkg::cfg_idx_t idx;
        idx = idx.first();
        for (int n = 0; n < idx.num(); n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= opts[idx];
            do @(posedge clk); while (!cfg_ready);
            fmt_tracker.write_option(idx, opts[idx]);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one input word after a random number of idle cycles and returns at
    // the edge where it is taken. push is left high so that a following word
    // with no gap goes out on the next cycle.
    task automatic send_word(input logic req, input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        req_type  <= req;
        data_byte <= b;
        do @(posedge clk); while (full);
        fmt_tracker.take_input(req, b);
    endtask

    // Stops sending and holds off until every expected word has come back,
    // then gives the block time to finish anything that emits nothing.
    task automatic settle();
        push <= 1'b0;
        while (fmt_tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random text: mostly ordinary lines with line ends, runs of blank lines
    // to exercise squeezing, tabs, arbitrary bytes and the odd end-of-file mark.
    task automatic send_text(input int unsigned n);
        int unsigned done_items;
        int unsigned pick;
        int unsigned run;
        done_items = 0;
        while (done_items < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_word(REQ_EOF, 8'($urandom));
                done_items++;
            end
            else if (pick < 10)
            begin
                run = $urandom_range(2, 4);
                repeat (run) send_word(REQ_DATA, tlfc_pkg::CH_LF);
                done_items += run;
            end
            else
            begin
                if (pick < 26)
                    send_word(REQ_DATA, tlfc_pkg::CH_LF);
                else if (pick < 32)
                    send_word(REQ_DATA, tlfc_pkg::CH_TAB);
                else if (pick < 50)
                    send_word(REQ_DATA, 8'($urandom));
                else
                    send_word(REQ_DATA, 8'($urandom_range(32, 126)));
                done_items++;
            end
        end
    endtask

    // Result side: pops with random idle cycles and occasional steady stretches.
    initial
    begin : result_drain
        int          gap;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            fmt_tracker.check_output(out_byte, last);
            taken++;
            if (taken % 40 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
        end
    end

    // Watchdog: any word moving on any channel restarts the count.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("text_line_formatter_caret_top_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        bit [5:0] opts;
        fmt_tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every option on. Blank lines squeeze after the first, blank lines get
        // no number, and each rendering path shows up once: NUL, tab as ^I,
        // DEL, the high control range, the two high bytes that map to quotes,
        // 255, and a plain double quote.
        apply_options('1);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_DATA, 8'd0);
        send_word(REQ_DATA, tlfc_pkg::CH_TAB);
        send_word(REQ_DATA, tlfc_pkg::CH_DEL);
        send_word(REQ_DATA, 8'd128);
        send_word(REQ_DATA, 8'd162);
        send_word(REQ_DATA, 8'd167);
        send_word(REQ_DATA, 8'd255);
        send_word(REQ_DATA, 8'd34);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        // End of file at a line start emits nothing; the next file counts from one.
        send_word(REQ_EOF, 8'h00);
        send_word(REQ_DATA, 8'd65);
        // End of file with the line still open closes it with a line end.
        send_word(REQ_EOF, 8'hFF);
        settle();

        // Non-printing display with every line numbered: a raw tab, a numbered
        // blank line, a high letter and the top of the control range.
        opts = '0;
        opts[tlfc_pkg::CFG_SHOW_NONPRINTING] = 1'b1;
        opts[tlfc_pkg::CFG_NUMBER_ALL] = 1'b1;
        apply_options(opts);
        send_word(REQ_DATA, tlfc_pkg::CH_TAB);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_DATA, 8'd200);
        send_word(REQ_DATA, 8'd31);
        send_word(REQ_DATA, tlfc_pkg::CH_LF);
        send_word(REQ_EOF, 8'h00);
        settle();

        // Random text in phases, each under its own option setting. The first two
        // phases take the extremes. Each phase ends with a full drain before the
        // options change. Counter saturation needs about a million numbered lines
        // and lies beyond the length of this run.
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                opts = '0;
            else if (phase == 1)
                opts = '1;
            else
                opts = 6'($urandom);
            apply_options(opts);
            tx_steady = ($urandom_range(0, 3) == 0);
            send_text(50);
            settle();
        end

        if (fmt_tracker.mismatches == 0 && fmt_tracker.pending() == 0)
            $display("text_line_formatter_caret_top_tb: PASS");
        else
            $display("text_line_formatter_caret_top_tb: FAIL");
        $finish;
    end
endmodule
